FILE: rtl/lsrc_pkg.sv
// ---------------------------------------------------------------------------
// lsrc_pkg: shared types, constants and functions
// Fixed-point log2 helpers and stage records for the log-scale rainbow
// colour map core.
// ---------------------------------------------------------------------------
package lsrc_pkg;

  localparam int FB     = 30;          // fraction bits of log2
  localparam int ZW     = FB + 1;      // squaring register, Q30 in [1,2)
  localparam int LW     = 40;          // signed log2 / difference width
  localparam int DW     = 50;          // division dividend width
  localparam int NSTEP  = FB;          // squaring steps
  localparam int QW     = 8;           // level width
  localparam int CFG_IW = 1;           // register index width

  localparam logic [CFG_IW-1:0] IDX_LOW_BOUND  = 1'b0;
  localparam logic [CFG_IW-1:0] IDX_HIGH_BOUND = 1'b1;

  localparam logic [31:0] LOW_BOUND_RESET  = 32'h42B4_0000;
  localparam logic [31:0] HIGH_BOUND_RESET = 32'h43C8_0000;
  localparam logic [31:0] POS_INF_BITS     = 32'h7F80_0000;

  typedef enum logic [2:0] {
    BND_LOAD,
    BND_SQUARE,
    BND_STORE,
    BND_SETTLE,
    BND_READY
  } bnd_state_t;

  typedef struct packed {
    logic                ok;
    logic [ZW-1:0]       z;
    logic signed [8:0]   e;
  } norm_t;

  typedef struct packed {
    logic [ZW-1:0] z;
    logic          bit_o;
  } sq_t;

  // bound results handed to the scaling stages
  typedef struct packed {
    logic                 ok;    // both bounds usable and distinct
    logic                 pos;   // hi above lo
    logic [LW-1:0]        den;   // magnitude of log2 hi - log2 lo
    logic signed [LW-1:0] llo;
  } bnd_t;

  typedef struct packed {
    logic [ZW-1:0]     z;
    logic [FB-1:0]     frac;
    logic signed [8:0] e;
    logic              inf;
    logic              bad;
    logic              eof;
  } lstage_t;

  typedef struct packed {
    logic                 inf;
    logic                 bad;
    logic                 eof;
    logic signed [LW-1:0] lx;
  } logv_t;

  typedef struct packed {
    logic [QW-1:0] level;
    logic          eof;
  } lvlv_t;

  // Split a single into a Q30 mantissa in [1,2) and an exponent.
  function automatic norm_t fp_norm(input logic [31:0] bits);
    norm_t       r;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [23:0] mm;
    logic [4:0]  p;
    ex = bits[30:23];
    m  = bits[22:0];
    p  = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) p = 5'(i);
    end
    if (ex == 8'd0) begin
      mm  = {1'b0, m} << (5'd23 - p);
      r.e = $signed({4'b0, p}) - 9'sd149;
    end else begin
      mm  = {1'b1, m};
      r.e = $signed({1'b0, ex}) - 9'sd127;
    end
    r.z  = {mm, 7'b0};
    r.ok = !bits[31] && (ex != 8'hFF) && (bits[30:0] != 31'd0);
    return r;
  endfunction

  // One squaring step: yields the next fraction bit of log2.
  function automatic sq_t sq_step(input logic [ZW-1:0] z);
    sq_t             r;
    logic [2*ZW-1:0] p;
    logic [31:0]     s;
    p = {{ZW{1'b0}}, z} * {{ZW{1'b0}}, z};
    s = p[2*FB+1:FB];
    if (s[31]) begin
      r.z     = s[31:1];
      r.bit_o = 1'b1;
    end else begin
      r.z     = s[30:0];
      r.bit_o = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [LW-1:0] lg_join(input logic signed [8:0] e,
                                                   input logic [FB-1:0] f);
    return $signed({e[8], e, f});
  endfunction

endpackage

FILE: rtl/lsrc_bound.sv
// ---------------------------------------------------------------------------
// lsrc_bound: bound registers and bound log2 sequencer
// Holds the two bound registers and works out their log2 difference with
// one shared squaring step, after reset and after every register write.
// ---------------------------------------------------------------------------
module lsrc_bound (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [lsrc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic                        busy,
  output lsrc_pkg::bnd_t              bnd
);
  import lsrc_pkg::*;

  bnd_state_t           state, state_next;
  logic [31:0]          lo_bits, hi_bits;
  logic                 sel;
  logic [4:0]           cnt;
  logic [ZW-1:0]        z;
  logic [FB-1:0]        frac;
  logic signed [8:0]    e;
  logic                 cur_ok, lo_ok, hi_ok;
  logic signed [LW-1:0] llo, lhi;

  norm_t                ld;
  sq_t                  sq;
  logic signed [LW-1:0] lcur, diff;

  always_comb begin
    state_next = state;
    case (state)
      BND_LOAD:   state_next = BND_SQUARE;
      BND_SQUARE: if (cnt == 5'(NSTEP - 1)) state_next = BND_STORE;
      BND_STORE:  state_next = sel ? BND_SETTLE : BND_LOAD;
      BND_SETTLE: state_next = BND_READY;
      BND_READY:  state_next = BND_READY;
      default:    state_next = BND_LOAD;
    endcase
  end

  always_comb begin
    busy = (state != BND_READY);
    ld   = fp_norm(sel ? hi_bits : lo_bits);
    sq   = sq_step(z);
    lcur = lg_join(e, frac);
    diff = lhi - llo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BND_LOAD;
      sel     <= 1'b0;
      lo_bits <= LOW_BOUND_RESET;
      hi_bits <= HIGH_BOUND_RESET;
    end else if (cfg_write_en) begin
      // restart the sequence on any write
      state <= BND_LOAD;
      sel   <= 1'b0;
      case (cfg_index)
        IDX_LOW_BOUND:  lo_bits <= cfg_data;
        IDX_HIGH_BOUND: hi_bits <= cfg_data;
        default: ;
      endcase
    end else begin
      state <= state_next;
      if (state == BND_STORE) sel <= ~sel;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BND_LOAD: begin
        z      <= ld.z;
        e      <= ld.e;
        cur_ok <= ld.ok;
        frac   <= '0;
        cnt    <= '0;
      end
      BND_SQUARE: begin
        z    <= sq.z;
        frac <= {frac[FB-2:0], sq.bit_o};
        cnt  <= cnt + 5'd1;
      end
      BND_STORE: begin
        if (sel) begin
          lhi   <= lcur;
          hi_ok <= cur_ok;
        end else begin
          llo   <= lcur;
          lo_ok <= cur_ok;
        end
      end
      BND_SETTLE: begin
        bnd.ok  <= lo_ok && hi_ok && (diff != '0);
        bnd.pos <= !diff[LW-1] && (diff != '0);
        bnd.den <= diff[LW-1] ? LW'(-diff) : LW'(diff);
        bnd.llo <= llo;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/lsrc_log.sv
// ---------------------------------------------------------------------------
// lsrc_log: sample log2 pipeline
// Unpacks the sample, then one squaring stage per fraction bit.
// ---------------------------------------------------------------------------
module lsrc_log (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [31:0]     sample_bits,
  input  logic            end_of_frame,
  output logic            out_valid,
  output lsrc_pkg::logv_t out_data
);
  import lsrc_pkg::*;

  logic    vld [0:NSTEP];
  lstage_t st  [0:NSTEP];
  norm_t   n;
  logic    is_inf;

  assign n      = fp_norm(sample_bits);
  assign is_inf = (sample_bits == POS_INF_BITS);

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].z    <= n.z;
      st[0].frac <= '0;
      st[0].e    <= n.e;
      st[0].inf  <= is_inf;
      st[0].bad  <= !n.ok && !is_inf;
      st[0].eof  <= end_of_frame;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_sq
    sq_t sq;
    assign sq = sq_step(st[k-1].z);

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (en) vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k].z    <= sq.z;
        st[k].frac <= {st[k-1].frac[FB-2:0], sq.bit_o};
        st[k].e    <= st[k-1].e;
        st[k].inf  <= st[k-1].inf;
        st[k].bad  <= st[k-1].bad;
        st[k].eof  <= st[k-1].eof;
      end
    end
  end

  assign out_valid    = vld[NSTEP];
  assign out_data.inf = st[NSTEP].inf;
  assign out_data.bad = st[NSTEP].bad;
  assign out_data.eof = st[NSTEP].eof;
  assign out_data.lx  = lg_join(st[NSTEP].e, st[NSTEP].frac);

endmodule

FILE: rtl/lsrc_div.sv
// ---------------------------------------------------------------------------
// lsrc_div: level scaling
// Forms the rounded ratio of log differences with a restoring divider,
// one quotient bit per stage, and applies the special cases.
// ---------------------------------------------------------------------------
module lsrc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  lsrc_pkg::logv_t in_data,
  input  lsrc_pkg::bnd_t  bnd,
  output logic            out_valid,
  output lsrc_pkg::lvlv_t out_data
);
  import lsrc_pkg::*;

  // numerator stage
  logic                 a_vld, a_inf, a_bad, a_eof;
  logic signed [LW-1:0] a_num;
  logic signed [LW-1:0] diff;

  assign diff = in_data.lx - bnd.llo;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num <= bnd.pos ? diff : -diff;
      a_inf <= in_data.inf;
      a_bad <= in_data.bad;
      a_eof <= in_data.eof;
    end
  end

  // dividend stage and division stages
  logic          vld  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [DW-1:0] d2   [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic          zero [0:QW];
  logic          sat  [0:QW];
  logic          inf  [0:QW];
  logic          bad  [0:QW];
  logic          eof  [0:QW];

  logic [DW-1:0] nu, den_w, dv, d2_w;

  always_comb begin
    nu    = {{(DW-LW){1'b0}}, a_num};
    den_w = {{(DW-LW){1'b0}}, bnd.den};
    dv    = (nu << 9) - (nu << 1) + den_w;   // 510 * num + den
    d2_w  = den_w << 1;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= dv;
      d2[0]   <= d2_w;
      q[0]    <= '0;
      zero[0] <= a_num[LW-1] || (a_num == '0);
      sat[0]  <= (dv >= (d2_w << QW));
      inf[0]  <= a_inf;
      bad[0]  <= a_bad;
      eof[0]  <= a_eof;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [DW-1:0] dsh;
    logic          fits;
    logic [QW-1:0] qn;

    always_comb begin
      dsh   = d2[k] << B;
      fits  = (rem[k] >= dsh);
      qn    = q[k];
      qn[B] = fits;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? rem[k] - dsh : rem[k];
        d2[k+1]   <= d2[k];
        q[k+1]    <= qn;
        zero[k+1] <= zero[k];
        sat[k+1]  <= sat[k];
        inf[k+1]  <= inf[k];
        bad[k+1]  <= bad[k];
        eof[k+1]  <= eof[k];
      end
    end
  end

  always_comb begin
    if (!bnd.ok)            out_data.level = '0;
    else if (inf[QW])       out_data.level = bnd.pos ? '1 : '0;
    else if (bad[QW])       out_data.level = '0;
    else if (zero[QW])      out_data.level = '0;
    else if (sat[QW])       out_data.level = '1;
    else                    out_data.level = q[QW];
    out_data.eof = eof[QW];
  end

  assign out_valid = vld[QW];

endmodule

FILE: rtl/lsrc_colour.sv
// ---------------------------------------------------------------------------
// lsrc_colour: rainbow colour stages
// Level to hue, then hue to RGB by the six-sector rule; the second stage
// is the output register.
// ---------------------------------------------------------------------------
module lsrc_colour (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  lsrc_pkg::lvlv_t in_data,
  output logic            out_valid,
  output logic [7:0]      level,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic            frame_done
);
  import lsrc_pkg::*;

  localparam logic [2:0] SEC_RED_YELLOW  = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYAN    = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE   = 3'd3;

  // hue stage: hue = (8177 - 32*level) / 34 by reciprocal
  logic        h_vld, h_eof;
  logic [7:0]  h_hue, h_lvl;
  logic [12:0] v;
  logic [27:0] hp;

  always_comb begin
    v  = 13'd8177 - {in_data.level, 5'b0};
    hp = {15'b0, v} * 28'd30841;
  end

  always_ff @(posedge clk) begin
    if (rst) h_vld <= 1'b0;
    else if (en) h_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_hue <= hp[27:20];
      h_lvl <= in_data.level;
      h_eof <= in_data.eof;
    end
  end

  // sector and ramps
  logic [16:0] sp;
  logic [2:0]  sector;
  logic [7:0]  sm, r8;
  logic [5:0]  r, rf;
  logic [9:0]  tr, tf;
  logic [7:0]  rise, fall, red_n, green_n, blue_n;

  always_comb begin
    sp      = {9'b0, h_hue} * 17'd274;
    sector  = sp[16:14];
    sm      = {5'b0, sector} * 8'd60;
    r8      = h_hue - sm;
    r       = r8[5:0];
    rf      = 6'd60 - r;
    tr      = {4'b0, r} * 10'd17 + 10'd2;
    tf      = {4'b0, rf} * 10'd17 + 10'd2;
    rise    = tr[9:2];
    fall    = tf[9:2];
    case (sector)
      SEC_RED_YELLOW: begin red_n = 8'hFF; green_n = rise;  blue_n = 8'h00; end
      SEC_YELLOW_GRN: begin red_n = fall;  green_n = 8'hFF; blue_n = 8'h00; end
      SEC_GRN_CYAN:   begin red_n = 8'h00; green_n = 8'hFF; blue_n = rise;  end
      SEC_CYAN_BLUE:  begin red_n = 8'h00; green_n = fall;  blue_n = 8'hFF; end
      default:        begin red_n = rise;  green_n = 8'h00; blue_n = 8'hFF; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= h_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level      <= h_lvl;
      red        <= red_n;
      green      <= green_n;
      blue       <= blue_n;
      frame_done <= h_eof;
    end
  end

endmodule

FILE: rtl/log_scale_rainbow_colormap_core.sv
// ---------------------------------------------------------------------------
// log_scale_rainbow_colormap_core: log-scaled rainbow colouring of pixels
// Maps single-precision intensities to an 8-bit log level and an RGB colour.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+------------------------------
//   sample   | sample_valid / sample_ready   | sample_bits, end_of_frame
//   result   | result_valid / result_ready   | level, red, green, blue,
//            |                               | frame_done
//   config   | cfg_write_en                  | cfg_index, cfg_data
//
// One pixel per cycle while neither a held result nor the bound sequencer
// stalls it; 31 log2 stages, 10 scaling stages, 2 colour stages.
// After reset and after every register write the bound log2 sequencer runs
// on its one squaring unit; sample_ready stays low meanwhile.
// A held result stalls the whole pipeline; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module log_scale_rainbow_colormap_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [lsrc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [31:0]                 sample_bits,
  input  logic                        end_of_frame,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [7:0]                  level,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic                        frame_done
);
  import lsrc_pkg::*;

  logic  busy, adv, log_valid, div_valid;
  bnd_t  bnd;
  logic  take;
  logv_t log_data;
  lvlv_t div_data;

  // advance everything unless the result is held
  assign adv          = !result_valid || result_ready;
  assign sample_ready = adv && !busy;
  assign take         = sample_valid && !busy;

  lsrc_bound u_bound (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .busy         (busy),
    .bnd          (bnd)
  );

  lsrc_log u_log (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (take),
    .sample_bits  (sample_bits),
    .end_of_frame (end_of_frame),
    .out_valid    (log_valid),
    .out_data     (log_data)
  );

  lsrc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (log_valid),
    .in_data   (log_data),
    .bnd       (bnd),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  lsrc_colour u_colour (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (div_valid),
    .in_data    (div_data),
    .out_valid  (result_valid),
    .level      (level),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_done (frame_done)
  );

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> !sample_ready)
    else $error("sample taken straight after a register write");

  a_top_level_red: assert property (@(posedge clk) disable iff (rst)
    result_valid && level == 8'hFF |-> red == 8'hFF && green == 8'h00 && blue == 8'h00)
    else $error("full level not shown as red");

  a_zero_level_blue: assert property (@(posedge clk) disable iff (rst)
    result_valid && level == 8'h00 |-> red == 8'h00 && green == 8'h00 && blue == 8'hFF)
    else $error("zero level not shown as blue");

endmodule

FILE: tb/lsrc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsrc_checker: pixel colouring predictor and result comparator
// Watches the sample and result channels, predicts level and colour in
// fixed point from the current bound registers, and counts mismatches.
// ---------------------------------------------------------------------------
module lsrc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        sample_valid,
  input  logic        sample_ready,
  input  logic [31:0] sample_bits,
  input  logic        end_of_frame,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [7:0]  level,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_done,
  output int          fail_count,
  output int          pending
);
  import lsrc_pkg::*;

  typedef struct {
    logic [7:0] lvl;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       eof;
  } pixel_colour_t;

  pixel_colour_t colour_q[$];
  logic [31:0]   lo_bits;
  logic [31:0]   hi_bits;

  // log2 in Q30; returns 0 for zero, negative, infinite or NaN patterns
  function automatic bit log2_q30(input logic [31:0] bits, output longint lg);
    int unsigned ex;
    int unsigned m;
    longint      e;
    longint unsigned z;
    longint      f;
    int          p;
    ex = bits[30:23];
    m  = bits[22:0];
    f  = 0;
    lg = 0;
    if (bits[31] || ex == 255 || (ex == 0 && m == 0)) return 0;
    if (ex == 0) begin
      p = 22;
      while (p > 0 && m[p] == 1'b0) p--;
      m = m << (23 - p);
      e = p - 149;
    end else begin
      m = m | 32'h80_0000;
      e = longint'(ex) - 127;
    end
    z = longint'(m) << 7;
    for (int k = 0; k < 30; k++) begin
      z = (z * z) >> 30;
      f = f * 2;
      if (z >= (64'd2 << 30)) begin
        f += 1;
        z >>= 1;
      end
    end
    lg = e * (64'sd1 << 30) + f;
    return 1;
  endfunction

  function automatic logic [7:0] log_level(input logic [31:0] x);
    longint llo, lhi, lx, num, den;
    longint unsigned q;
    if (!log2_q30(lo_bits, llo) || !log2_q30(hi_bits, lhi)) return 0;
    den = lhi - llo;
    if (den == 0) return 0;
    if (x == POS_INF_BITS) return den > 0 ? 8'd255 : 8'd0;
    if (!log2_q30(x, lx)) return 0;
    num = lx - llo;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    q = (longint'(num) * 510 + den) / (den * 2);
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_colour_t colour_pixel(input logic [31:0] x, input logic eof);
    pixel_colour_t c;
    int unsigned hue, r, rise, fall;
    c.lvl = log_level(x);
    c.eof = eof;
    hue  = (2 * (4080 - 16 * c.lvl) + 17) / 34;
    r    = hue % 60;
    rise = (17 * r + 2) / 4;
    fall = (17 * (60 - r) + 2) / 4;
    case (hue / 60)
      0: begin c.r = 255;  c.g = rise; c.b = 0;   end
      1: begin c.r = fall; c.g = 255;  c.b = 0;   end
      2: begin c.r = 0;    c.g = 255;  c.b = rise; end
      3: begin c.r = 0;    c.g = fall; c.b = 255; end
      default: begin c.r = rise; c.g = 0; c.b = 255; end
    endcase
    return c;
  endfunction

  assign pending = colour_q.size();

  always @(posedge clk) begin
    pixel_colour_t want;
    if (rst) begin
      lo_bits <= LOW_BOUND_RESET;
      hi_bits <= HIGH_BOUND_RESET;
      colour_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == IDX_LOW_BOUND) lo_bits <= cfg_data;
        else                            hi_bits <= cfg_data;
      end
      if (sample_valid && sample_ready)
        colour_q.push_back(colour_pixel(sample_bits, end_of_frame));
      if (result_valid && result_ready) begin
        if (colour_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = colour_q.pop_front();
          if (level !== want.lvl || red !== want.r || green !== want.g ||
              blue !== want.b || frame_done !== want.eof) begin
            if (level !== want.lvl) $error("level exp %0d got %0d", want.lvl, level);
            if (red !== want.r) $error("red exp %0d got %0d", want.r, red);
            if (green !== want.g) $error("green exp %0d got %0d", want.g, green);
            if (blue !== want.b) $error("blue exp %0d got %0d", want.b, blue);
            if (frame_done !== want.eof)
              $error("frame_done exp %0d got %0d", want.eof, frame_done);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: log-scale rainbow colour map regression
// Drives directed and random pixels through several bound settings with
// random idling on both channels; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;
  import lsrc_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write_en = 0;
  logic        cfg_index = IDX_LOW_BOUND;
  logic [31:0] cfg_data = 0;
  logic        sample_valid = 0;
  logic        sample_ready;
  logic [31:0] sample_bits = 0;
  logic        end_of_frame = 0;
  logic        result_valid;
  logic        result_ready = 0;
  logic [7:0]  level, red, green, blue;
  logic        frame_done;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          calm = 0;
  logic [31:0] lo_now = LOW_BOUND_RESET;
  logic [31:0] hi_now = HIGH_BOUND_RESET;

  always #5 clk = ~clk;

  log_scale_rainbow_colormap_core u_dut (.*);

  lsrc_checker u_chk (.*);

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("log_scale_rainbow_colormap_core regression: fail");
      $finish;
    end
  end

  // receiver: stall in random bursts until the calm tail
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = calm ? 1 : $urandom_range(1, 30);
      if (!calm && $urandom_range(0, 2) == 0) begin
        @(posedge clk) result_ready <= 0;
        repeat ($urandom_range(0, 17)) @(posedge clk);
      end
      @(posedge clk) result_ready <= 1;
      repeat (n - 1) @(posedge clk);
    end
  end

  // hold valid across back-to-back transfers; drop it only for an idle burst
  task automatic send_pixel(input logic [31:0] x, input logic eof);
    if (!calm && $urandom_range(0, 7) == 0) begin
      sample_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    sample_valid <= 1;
    sample_bits  <= x;
    end_of_frame <= eof;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic write_bound(input logic idx, input logic [31:0] v);
    sample_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    @(posedge clk);
    cfg_write_en <= 1;
    cfg_index    <= idx;
    cfg_data     <= v;
    @(posedge clk) cfg_write_en <= 0;
    if (idx == IDX_LOW_BOUND) lo_now = v;
    else                      hi_now = v;
  endtask

  // mostly intensities near the current bounds, sometimes any pattern
  function automatic logic [31:0] pick_pixel();
    logic [31:0] b;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {1'b0, 8'd0, 23'($urandom())};
      2: return {1'b0, 8'hFF, 23'($urandom_range(0, 1) ? 0 : $urandom())};
      default: begin
        b = $urandom_range(0, 1) ? lo_now : hi_now;
        return b + 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
      end
    endcase
  endfunction

  task automatic random_pixels(input int n);
    for (int i = 0; i < n; i++)
      send_pixel(pick_pixel(), $urandom_range(0, 15) == 0);
  endtask

  initial begin
    logic [31:0] edge_px[15] = '{32'h0, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
                                 32'h0080_0000, 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'hBF80_0000, 32'h42B4_0000,
                                 32'h43C8_0000, 32'h4316_0000, 32'h3F80_0000};
    repeat (9) @(posedge clk);
    rst <= 0;
    foreach (edge_px[i]) send_pixel(edge_px[i], i[0]);
    for (int l = 0; l < 8; l++)  // walk the hue sectors
      send_pixel(32'h42B4_0000 + l * 32'h0020_0000, 1'b0);
    random_pixels(400);
    write_bound(IDX_LOW_BOUND, 32'h3F80_0000);
    write_bound(IDX_HIGH_BOUND, 32'h7F7F_FFFF);
    random_pixels(250);
    // inverted scale
    write_bound(IDX_LOW_BOUND, 32'h4400_0000);
    write_bound(IDX_HIGH_BOUND, 32'h4120_0000);
    random_pixels(250);
    write_bound(IDX_LOW_BOUND, 32'h0000_0001);
    write_bound(IDX_HIGH_BOUND, 32'h0000_0002);
    random_pixels(150);
    // equal bounds, then unusable bounds
    write_bound(IDX_HIGH_BOUND, 32'h0000_0001);
    random_pixels(60);
    write_bound(IDX_LOW_BOUND, 32'hFFFF_FFFF);
    random_pixels(40);
    write_bound(IDX_LOW_BOUND, 32'h0);
    write_bound(IDX_HIGH_BOUND, 32'h7F80_0000);
    random_pixels(40);
    write_bound(IDX_LOW_BOUND, $urandom());
    write_bound(IDX_HIGH_BOUND, $urandom());
    random_pixels(100);
    write_bound(IDX_LOW_BOUND, LOW_BOUND_RESET);
    write_bound(IDX_HIGH_BOUND, HIGH_BOUND_RESET);
    random_pixels(200);
    calm = 1;
    random_pixels(150);
    sample_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("log_scale_rainbow_colormap_core regression: pass");
    else
      $display("log_scale_rainbow_colormap_core regression: fail");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lsrc_pkg.sv
rtl/lsrc_bound.sv
rtl/lsrc_log.sv
rtl/lsrc_div.sv
rtl/lsrc_colour.sv
rtl/log_scale_rainbow_colormap_core.sv
tb/lsrc_checker.sv
tb/tb.sv
